// ----- hdl/ppmc_pkg.sv -----
// ----------------------------------------------------------------------------
// ppmc_pkg
// Shared constants, types and helpers for the page permission map checker.
// ----------------------------------------------------------------------------
package ppmc_pkg;

   localparam int PAGE_SHIFT = 12;
   // page count is a power of two, so the page index is a mask of the page number
   localparam int NUM_PAGES  = 1048576;
   localparam int PAGE_BITS  = $clog2(NUM_PAGES);

   typedef logic [PAGE_BITS-1:0] page_type;

   localparam page_type PAGE_LAST = page_type'(NUM_PAGES - 1);

   localparam logic [2:0] FUNC_REG   = 3'd0;
   localparam logic [2:0] FUNC_UNREG = 3'd1;
   localparam logic [2:0] FUNC_READ  = 3'd2;
   localparam logic [2:0] FUNC_WRITE = 3'd3;
   localparam logic [2:0] FUNC_EXEC  = 3'd4;

   localparam logic [3:0] PERM_NONE = 4'h0;
   localparam logic [3:0] PERM_R    = 4'h1;
   localparam logic [3:0] PERM_W    = 4'h2;
   localparam logic [3:0] PERM_X    = 4'h4;
   localparam logic [3:0] PERM_A    = 4'h8;

   localparam logic [1:0] KIND_NONE    = 2'd0;
   localparam logic [1:0] KIND_AV      = 2'd1;
   localparam logic [1:0] KIND_GUARD   = 2'd2;
   localparam logic [1:0] KIND_ANOMALY = 2'd3;

   typedef struct packed {
      logic found;
      logic mism;
      logic chg;
      logic unset;
   } flags_type;

   typedef struct packed {
      logic        precheck;
      logic [1:0]  fault_kind;
      logic [31:0] fault_addr;
      flags_type   flags;
   } result_type;

   typedef struct packed {
      logic       rd_en;
      page_type   rd_addr;
      logic       wr_en;
      page_type   wr_addr;
      logic [3:0] wr_data;
   } mem_req_type;

   function automatic page_type page_of(input logic [31:0] addr);
      logic [31:0] vpn;
      vpn = addr >> PAGE_SHIFT;
      return vpn[PAGE_BITS-1:0];
   endfunction

endpackage

// ----- hdl/ppmc_req_if.sv -----
// ----------------------------------------------------------------------------
// ppmc_req_if
// Request channel: operation code, address, range size, mask and pc.
// ----------------------------------------------------------------------------
interface ppmc_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  func;
   logic [31:0] address;
   logic [31:0] range_size;
   logic [3:0]  new_perm;
   logic [31:0] pc;

   modport source (output valid, output func, output address, output range_size,
                   output new_perm, output pc, input ready);
   modport sink   (input valid, input func, input address, input range_size,
                   input new_perm, input pc, output ready);
endinterface

// ----- hdl/ppmc_rsp_if.sv -----
// ----------------------------------------------------------------------------
// ppmc_rsp_if
// Response channel: check verdict and range operation flags.
// ----------------------------------------------------------------------------
interface ppmc_rsp_if;
   logic        valid;
   logic        ready;
   logic        precheck;
   logic [1:0]  fault_kind;
   logic [31:0] fault_addr;
   logic        page_found;
   logic        page_mismatch;
   logic        perm_changed;
   logic        unset_seen;

   modport source (output valid, output precheck, output fault_kind, output fault_addr,
                   output page_found, output page_mismatch, output perm_changed,
                   output unset_seen, input ready);
   modport sink   (input valid, input precheck, input fault_kind, input fault_addr,
                   input page_found, input page_mismatch, input perm_changed,
                   input unset_seen, output ready);
endinterface

// ----- hdl/ppmc_store.sv -----
// ----------------------------------------------------------------------------
// ppmc_store
// Page mask memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ppmc_store (
   input  logic                  clock,
   input  ppmc_pkg::mem_req_type mem_req,
   output logic [3:0]            rd_data
);
   import ppmc_pkg::*;

   logic [3:0] perm_mem [NUM_PAGES];
   logic [3:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         perm_mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= perm_mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/ppmc_eval.sv -----
// ----------------------------------------------------------------------------
// ppmc_eval
// Verdict logic: check faults from one page mask, range flags merged with
// the flags gathered over earlier pages.
// ----------------------------------------------------------------------------
module ppmc_eval (
   input  logic [2:0]           func,
   input  logic [31:0]          address,
   input  logic [3:0]           new_perm,
   input  logic [31:0]          pc,
   input  logic [3:0]           mask,
   input  ppmc_pkg::flags_type  acc,
   output ppmc_pkg::result_type result
);
   import ppmc_pkg::*;

   logic [3:0] right;

   assign right = (func == FUNC_READ) ? PERM_R : PERM_W;

   always_comb begin
      result = '0;
      case (func)
         FUNC_REG: begin
            result.flags.found = acc.found | (mask != PERM_NONE);
            result.flags.mism  = acc.mism | ((mask != PERM_NONE) && (mask != new_perm));
            result.flags.chg   = acc.chg | (mask != new_perm);
         end
         FUNC_UNREG: begin
            result.flags.unset = acc.unset | (mask == PERM_NONE);
         end
         FUNC_READ, FUNC_WRITE: begin
            result.precheck = ((mask & (right | PERM_A)) == PERM_NONE);
            if (mask == PERM_NONE) begin
               result.fault_kind = KIND_AV;
               result.fault_addr = pc;
            end else if ((mask & PERM_A) == PERM_NONE) begin
               result.fault_kind = KIND_ANOMALY;
            end else if ((mask & right) == PERM_NONE) begin
               result.fault_kind = KIND_AV;
               result.fault_addr = (func == FUNC_READ) ? address : pc;
            end
         end
         FUNC_EXEC: begin
            result.precheck = ((mask & (PERM_X | PERM_A)) == PERM_NONE);
            if ((mask & PERM_A) == PERM_NONE) begin
               result.fault_kind = KIND_GUARD;
               result.fault_addr = pc;
            end else if ((mask & PERM_X) == PERM_NONE) begin
               result.fault_kind = KIND_AV;
               result.fault_addr = pc;
            end
         end
         default: begin
            result = '0;
         end
      endcase
   end

endmodule

// ----- hdl/ppmc_seq.sv -----
// ----------------------------------------------------------------------------
// ppmc_seq
// Sequencer: clearing pass after reset, single-page lookups, and the
// read-modify-write walk over a page range, with the response register.
// ----------------------------------------------------------------------------
module ppmc_seq (
   input  logic                  clock,
   input  logic                  reset,
   ppmc_req_if.sink              req_bus,
   ppmc_rsp_if.source            rsp_bus,
   output ppmc_pkg::mem_req_type mem_req,
   input  logic [3:0]            rd_data
);
   import ppmc_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR = 4'b0001,
      ST_IDLE  = 4'b0010,
      ST_LOOK  = 4'b0100,
      ST_WALK  = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   page_type    cur_ff, cur_in;
   page_type    last_ff, last_in;
   logic [2:0]  func_ff, func_in;
   logic [31:0] addr_ff, addr_in;
   logic [3:0]  perm_ff, perm_in;
   logic [31:0] pc_ff, pc_in;
   flags_type   acc_ff, acc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  rsp_data_ff, rsp_data_in;

   result_type  eval_res;
   logic        accept;
   logic        out_free;
   logic        load_out;
   page_type    start_page;
   page_type    end_page;

   ppmc_eval u_eval (
      .func     (func_ff),
      .address  (addr_ff),
      .new_perm (perm_ff),
      .pc       (pc_ff),
      .mask     (rd_data),
      .acc      (acc_ff),
      .result   (eval_res)
   );

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign accept        = req_bus.valid & req_bus.ready;
   assign out_free      = ~rsp_valid_ff | rsp_bus.ready;
   assign start_page    = page_of(req_bus.address);
   assign end_page      = (req_bus.range_size == 32'd0) ? start_page :
                          page_of(req_bus.address + req_bus.range_size - 32'd1);

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      last_in  = last_ff;
      func_in  = func_ff;
      addr_in  = addr_ff;
      perm_in  = perm_ff;
      pc_in    = pc_ff;
      acc_in   = acc_ff;
      load_out = 1'b0;
      mem_req  = '0;
      case (state_ff)
         ST_CLEAR: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff;
            mem_req.wr_data = PERM_NONE;
            cur_in          = cur_ff + page_type'(1);
            if (cur_ff == PAGE_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               func_in         = req_bus.func;
               addr_in         = req_bus.address;
               perm_in         = req_bus.new_perm;
               pc_in           = req_bus.pc;
               acc_in          = '0;
               cur_in          = start_page;
               last_in         = end_page;
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = start_page;
               if ((req_bus.func == FUNC_REG) || (req_bus.func == FUNC_UNREG)) begin
                  state_in = ST_WALK;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_WALK: begin
            // write back the current page, whose mask the store has read, and read the next page unless it is the last
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = cur_ff;
            mem_req.wr_data = (func_ff == FUNC_REG) ? perm_ff : PERM_NONE;
            if (cur_ff == last_ff) begin
               if (out_free) begin
                  load_out = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               acc_in          = eval_res.flags;
               cur_in          = cur_ff + page_type'(1);
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = cur_ff + page_type'(1);
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   assign rsp_valid_in = load_out | (rsp_valid_ff & ~rsp_bus.ready);
   assign rsp_data_in  = load_out ? eval_res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff     <= last_in;
      func_ff     <= func_in;
      addr_ff     <= addr_in;
      perm_ff     <= perm_in;
      pc_ff       <= pc_in;
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.precheck      = rsp_data_ff.precheck;
   assign rsp_bus.fault_kind    = rsp_data_ff.fault_kind;
   assign rsp_bus.fault_addr    = rsp_data_ff.fault_addr;
   assign rsp_bus.page_found    = rsp_data_ff.flags.found;
   assign rsp_bus.page_mismatch = rsp_data_ff.flags.mism;
   assign rsp_bus.perm_changed  = rsp_data_ff.flags.chg;
   assign rsp_bus.unset_seen    = rsp_data_ff.flags.unset;

   // read and write of one cycle never hit the same page
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      (mem_req.rd_en && mem_req.wr_en) |-> (mem_req.rd_addr != mem_req.wr_addr))
      else $error("read and write collide on one page");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> ((state_ff == ST_LOOK) || (state_ff == ST_WALK)))
      else $error("accepted beat did not start work");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_valid_ff)
      else $error("response during clearing pass");

   a_walk_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> mem_req.wr_en)
      else $error("range walk without write back");

endmodule

// ----- hdl/page_permission_map_checker_unit.sv -----
// ----------------------------------------------------------------------------
// page_permission_map_checker_unit
// Per-page 4-bit permission map with range register/unregister and
// read, write and execute checks.
//
//   channel   dir   beat carries
//   req_bus   in    func, address, range_size, new_perm, pc
//   rsp_bus   out   precheck, fault_kind, fault_addr, page_found,
//                   page_mismatch, perm_changed, unset_seen
//
// checks: accept with memory read, then verdict into the output register
// range operations do one read-modify-write per page, for each of the N pages
// after reset a clearing pass writes zero to all NUM_PAGES (1048576) pages; req_bus.ready is low
// one item is in work at a time; a new beat is taken while a response still waits
// a stalled response holds the finishing item until the output register frees
// ----------------------------------------------------------------------------
module page_permission_map_checker_unit (
   input  logic       clock,
   input  logic       reset,
   ppmc_req_if.sink   req_bus,
   ppmc_rsp_if.source rsp_bus
);
   import ppmc_pkg::*;

   mem_req_type mem_req;
   logic [3:0]  rd_data;

   ppmc_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   ppmc_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule
